/* rtl/latq_pkg.sv */
// Shared types and constants of the look-at to quaternion pipeline.
`default_nettype none

package latq_pkg;

	// Coordinate width of the eye, target and up inputs (signed Q16.16)
	localparam int COORD_WIDTH = 32;
	// Width of one quaternion component (signed Q2.30)
	localparam int Q_W = 32;
	// Block scaling puts the largest magnitude at this bit
	localparam int SCALE_MSB = 29;
	// Signed width of a block-scaled component
	localparam int SCALE_W = SCALE_MSB + 2;
	// One in Q2.30
	localparam int ONE_Q30 = 1 << 30;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] eye_x;
		logic signed [COORD_WIDTH-1:0] eye_y;
		logic signed [COORD_WIDTH-1:0] eye_z;
		logic signed [COORD_WIDTH-1:0] target_x;
		logic signed [COORD_WIDTH-1:0] target_y;
		logic signed [COORD_WIDTH-1:0] target_z;
		logic signed [COORD_WIDTH-1:0] up_x;
		logic signed [COORD_WIDTH-1:0] up_y;
		logic signed [COORD_WIDTH-1:0] up_z;
	} in_t;

	typedef struct packed {
		logic signed [Q_W-1:0] quat_x;
		logic signed [Q_W-1:0] quat_y;
		logic signed [Q_W-1:0] quat_z;
		logic signed [Q_W-1:0] quat_w;
		logic                  degenerate;
	} out_t;

	// Which matrix-to-quaternion branch an item takes
	typedef enum logic [1:0] {
		BR_TRACE,
		BR_X,
		BR_Y,
		BR_Z
	} branch_t;

endpackage

`default_nettype wire

/* rtl/look_at_to_quaternion_unit.sv */
// Top level: look-at frame to orientation quaternion, deep pipeline.
//
//   channel | signals                       | direction | payload
//   --------+-------------------------------+-----------+---------------------------
//   input   | in_valid, in_ready, in_data   | in        | eye, target, up (Q16.16)
//   output  | out_valid, out_ready, out_data| out       | quat x/y/z/w (Q2.30), flag
//
// One transfer is taken every cycle while the output is not stalled; the
// depth is set by the two square root pipelines (one bit a stage)
// and the two restoring divider pipelines (one quotient bit a stage).
// arst_n clears only the valid bits. When the output register holds a
// result that is not taken, the whole pipeline holds and in_ready drops.
`default_nettype none

module look_at_to_quaternion_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  latq_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output latq_pkg::out_t   out_data
);
	import latq_pkg::*;

	localparam int W      = COORD_WIDTH;
	localparam int MW     = W + 1;
	localparam int CW     = 2 * SCALE_W;           // cross product width
	localparam int SQ1_NB = 2 * SCALE_W;           // normalize radicand width
	localparam int LEN_W  = SQ1_NB / 2;
	localparam int D1_NW  = 2 * (SCALE_MSB + 1);   // |v| << 30
	localparam int MV     = 36;                    // matrix entry width
	localparam int RAD_W  = 34;
	localparam int SQ2_NB = RAD_W + 30;
	localparam int S_W    = SQ2_NB / 2;
	localparam int D2_NW  = MV + SCALE_MSB;
	localparam int BS_LAT = 2;
	localparam int DV_LAT = Q_W + 1;
	localparam int LAT    = 2 + BS_LAT + 3 + BS_LAT + 2 + SQ1_NB / 2 + DV_LAT + 6
	                        + SQ2_NB / 2 + DV_LAT + 1;

	logic en;
	logic [LAT-1:0] vld_q;

	// global advance: stall only when a finished result waits
	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// stage 1: eye minus target
	logic signed [W:0]   d_s1  [3];
	logic signed [W-1:0] up_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0]  <= (W+1)'(in_data.eye_x) - (W+1)'(in_data.target_x);
			d_s1[1]  <= (W+1)'(in_data.eye_y) - (W+1)'(in_data.target_y);
			d_s1[2]  <= (W+1)'(in_data.eye_z) - (W+1)'(in_data.target_z);
			up_s1[0] <= in_data.up_x;
			up_s1[1] <= in_data.up_y;
			up_s1[2] <= in_data.up_z;
		end
	end

	// stage 2: sign and magnitude
	logic [MW-1:0] dmag_s2 [3];
	logic [MW-1:0] umag_s2 [3];
	logic [2:0]    dneg_s2;
	logic [2:0]    uneg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dmag_s2[i] <= d_s1[i][W] ? MW'(-d_s1[i]) : MW'(d_s1[i]);
				dneg_s2[i] <= d_s1[i][W];
				// magnitude of the most negative value is 2^(W-1), kept unsigned
				umag_s2[i] <= up_s1[i][W-1] ? MW'($unsigned(-up_s1[i]))
				                            : MW'($unsigned(up_s1[i]));
				uneg_s2[i] <= up_s1[i][W-1];
			end
		end
	end

	// stages 3-4: block scaling
	logic signed [SCALE_W-1:0] sd_s4 [3];
	logic signed [SCALE_W-1:0] su_s4 [3];

	latq_bscale #(.MW(MW)) u_bs_d (
		.clk(clk), .en(en), .mag(dmag_s2), .neg(dneg_s2), .sv(sd_s4), .zero()
	);
	latq_bscale #(.MW(MW)) u_bs_u (
		.clk(clk), .en(en), .mag(umag_s2), .neg(uneg_s2), .sv(su_s4), .zero()
	);

	// stage 5: cross product terms
	logic signed [CW-1:0] p_s5 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5[0] <= sd_s4[1] * su_s4[2];
			p_s5[1] <= sd_s4[2] * su_s4[1];
			p_s5[2] <= sd_s4[2] * su_s4[0];
			p_s5[3] <= sd_s4[0] * su_s4[2];
			p_s5[4] <= sd_s4[0] * su_s4[1];
			p_s5[5] <= sd_s4[1] * su_s4[0];
		end
	end

	// stages 6-7: cross product, then its sign and magnitude
	logic signed [CW-1:0] c_s6    [3];
	logic [CW-2:0]        cmag_s7 [3];
	logic [2:0]           cneg_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s6[i]    <= p_s5[2*i] - p_s5[2*i+1];
				cmag_s7[i] <= c_s6[i][CW-1] ? (CW-1)'(-c_s6[i]) : (CW-1)'(c_s6[i]);
				cneg_s7[i] <= c_s6[i][CW-1];
			end
		end
	end

	// stages 8-9: scale the right axis; a zero cross product flags the item
	logic signed [SCALE_W-1:0] sc_s9 [3];
	logic                      deg_s9;

	latq_bscale #(.MW(CW-1)) u_bs_c (
		.clk(clk), .en(en), .mag(cmag_s7), .neg(cneg_s7), .sv(sc_s9), .zero(deg_s9)
	);

	// forward axis waits for the right axis
	logic [3*SCALE_W-1:0]      sd_flat;
	logic signed [SCALE_W-1:0] sd_s9 [3];

	latq_delay #(.WD(3*SCALE_W), .DEPTH(3 + BS_LAT)) u_dl_sd (
		.clk(clk), .en(en), .din({sd_s4[0], sd_s4[1], sd_s4[2]}), .dout(sd_flat)
	);
	assign sd_s9[0] = sd_flat[3*SCALE_W-1:2*SCALE_W];
	assign sd_s9[1] = sd_flat[2*SCALE_W-1:SCALE_W];
	assign sd_s9[2] = sd_flat[SCALE_W-1:0];

	// stage 10: squares and magnitudes of both axes (0..2 forward, 3..5 right)
	logic signed [CW-1:0]  sq_s10  [6];
	logic [SCALE_MSB:0]    vmag_s10 [6];
	logic [5:0]            vneg_s10;
	logic signed [SCALE_W-1:0] v_s9 [6];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v_s9[i]   = sd_s9[i];
			v_s9[3+i] = sc_s9[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				sq_s10[i]   <= v_s9[i] * v_s9[i];
				vmag_s10[i] <= v_s9[i][SCALE_W-1] ? (SCALE_MSB+1)'(-v_s9[i])
				                                  : (SCALE_MSB+1)'(v_s9[i]);
				vneg_s10[i] <= v_s9[i][SCALE_W-1];
			end
		end
	end

	// stage 11: sums of squares
	logic [SQ1_NB-1:0] ss_s11 [2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				ss_s11[k] <= SQ1_NB'(sq_s10[3*k]) + SQ1_NB'(sq_s10[3*k+1])
				             + SQ1_NB'(sq_s10[3*k+2]);
			end
		end
	end

	// lengths by square root
	logic [LEN_W-1:0] len [2];

	for (genvar k = 0; k < 2; k++) begin : g_len
		latq_isqrt #(.NB(SQ1_NB)) u_sqrt (
			.clk(clk), .en(en), .rad(ss_s11[k]), .root(len[k])
		);
	end

	// magnitudes wait for the lengths, signs wait for the quotients
	logic [6*(SCALE_MSB+1)-1:0] vmag_flat;
	logic [5:0]                 vneg_dl;

	latq_delay #(.WD(6*(SCALE_MSB+1)), .DEPTH(SQ1_NB/2 + 1)) u_dl_vmag (
		.clk(clk), .en(en),
		.din({vmag_s10[0], vmag_s10[1], vmag_s10[2], vmag_s10[3], vmag_s10[4],
		      vmag_s10[5]}),
		.dout(vmag_flat)
	);
	latq_delay #(.WD(6), .DEPTH(SQ1_NB/2 + 1 + DV_LAT)) u_dl_vneg (
		.clk(clk), .en(en), .din(vneg_s10), .dout(vneg_dl)
	);

	// unit vectors by rounded division
	logic [Q_W-1:0] nq [6];

	for (genvar i = 0; i < 6; i++) begin : g_norm
		latq_div #(.NW(D1_NW), .DW(LEN_W), .QW(Q_W)) u_div (
			.clk(clk), .en(en),
			.mag({vmag_flat[(6-i)*(SCALE_MSB+1)-1 -: (SCALE_MSB+1)],
			      (SCALE_MSB+1)'(0)}),
			.den(len[i/3]),
			.quo(nq[i]), .ovf()
		);
	end

	// stage 76: signed unit axes (0..2 forward, 3..5 right)
	logic signed [Q_W-1:0] fr_s76 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				fr_s76[i] <= vneg_dl[i] ? -nq[i] : nq[i];
			end
		end
	end

	// stage 77: products for the third axis
	logic signed [2*Q_W-1:0] pu_s77 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s77[0] <= fr_s76[1] * fr_s76[5];
			pu_s77[1] <= fr_s76[2] * fr_s76[4];
			pu_s77[2] <= fr_s76[2] * fr_s76[3];
			pu_s77[3] <= fr_s76[0] * fr_s76[5];
			pu_s77[4] <= fr_s76[0] * fr_s76[4];
			pu_s77[5] <= fr_s76[1] * fr_s76[3];
		end
	end

	// stages 78-79: difference, then round to Q2.30 half away from zero
	logic signed [2*Q_W-1:0] ud_s78 [3];
	logic signed [MV-1:0]    u_s79  [3];
	logic [2*Q_W-1:0]        umag;
	logic [2*Q_W-1:0]        urnd   [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			umag    = ud_s78[i][2*Q_W-1] ? (2*Q_W)'(-ud_s78[i]) : (2*Q_W)'(ud_s78[i]);
			urnd[i] = (umag + (2*Q_W)'(ONE_Q30 / 2)) >> 30;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ud_s78[i] <= pu_s77[2*i] - pu_s77[2*i+1];
				u_s79[i]  <= ud_s78[i][2*Q_W-1] ? -MV'(urnd[i][MV-2:0])
				                                : MV'(urnd[i][MV-2:0]);
			end
		end
	end

	// forward and right axes wait for the third axis
	logic [6*Q_W-1:0] fr_flat;

	latq_delay #(.WD(6*Q_W), .DEPTH(3)) u_dl_fr (
		.clk(clk), .en(en),
		.din({fr_s76[0], fr_s76[1], fr_s76[2], fr_s76[3], fr_s76[4], fr_s76[5]}),
		.dout(fr_flat)
	);

	// matrix rows: right, third, forward
	logic signed [MV-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	assign m00 = MV'($signed(fr_flat[3*Q_W-1:2*Q_W]));
	assign m01 = MV'($signed(fr_flat[2*Q_W-1:Q_W]));
	assign m02 = MV'($signed(fr_flat[Q_W-1:0]));
	assign m10 = u_s79[0];
	assign m11 = u_s79[1];
	assign m12 = u_s79[2];
	assign m20 = MV'($signed(fr_flat[6*Q_W-1:5*Q_W]));
	assign m21 = MV'($signed(fr_flat[5*Q_W-1:4*Q_W]));
	assign m22 = MV'($signed(fr_flat[4*Q_W-1:3*Q_W]));

	// stage 80: trace, branch radicands, diagonal compares, numerator candidates
	logic signed [MV-1:0] tr_s80;
	logic signed [MV-1:0] radx_s80, rady_s80, radz_s80;
	logic                 ge01_s80, ge02_s80, gt12_s80;
	logic signed [MV-1:0] na_s80, nb_s80, nc_s80, nd_s80, ne_s80, ng_s80;

	always_ff @(posedge clk) begin
		if (en) begin
			tr_s80   <= m00 + m11 + m22;
			radx_s80 <= MV'(ONE_Q30) + m00 - m11 - m22;
			rady_s80 <= MV'(ONE_Q30) + m11 - m00 - m22;
			radz_s80 <= MV'(ONE_Q30) + m22 - m00 - m11;
			ge01_s80 <= (m00 >= m11);
			ge02_s80 <= (m00 >= m22);
			gt12_s80 <= (m11 > m22);
			na_s80   <= m12 - m21;
			nb_s80   <= m20 - m02;
			nc_s80   <= m01 - m10;
			nd_s80   <= m01 + m10;
			ne_s80   <= m02 + m20;
			ng_s80   <= m21 + m12;
		end
	end

	// stage 81: branch select, clamped radicand, three numerators
	branch_t              br_d;
	logic signed [MV-1:0] rad_sel;
	logic signed [MV-1:0] num_d [3];

	branch_t              br_s81;
	logic [RAD_W-1:0]     rad_s81;
	logic signed [MV-1:0] num_s81 [3];

	always_comb begin
		if (tr_s80 > 0) begin
			br_d = BR_TRACE;
		end else if (ge01_s80 && ge02_s80) begin
			br_d = BR_X;
		end else if (gt12_s80) begin
			br_d = BR_Y;
		end else begin
			br_d = BR_Z;
		end
		case (br_d)
			BR_TRACE: begin
				rad_sel  = tr_s80 + MV'(ONE_Q30);
				num_d[0] = na_s80; num_d[1] = nb_s80; num_d[2] = nc_s80;
			end
			BR_X: begin
				rad_sel  = radx_s80;
				num_d[0] = nd_s80; num_d[1] = ne_s80; num_d[2] = na_s80;
			end
			BR_Y: begin
				rad_sel  = rady_s80;
				num_d[0] = nd_s80; num_d[1] = ng_s80; num_d[2] = nb_s80;
			end
			default: begin
				rad_sel  = radz_s80;
				num_d[0] = ne_s80; num_d[1] = ng_s80; num_d[2] = nc_s80;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			br_s81  <= br_d;
			rad_s81 <= rad_sel[MV-1] ? '0 : RAD_W'(rad_sel);
			num_s81 <= num_d;
		end
	end

	// stage 82: numerator sign and magnitude
	logic [MV-1:0] nmag_s82 [3];
	logic [2:0]    nneg_s82;
	branch_t       br_s82;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nmag_s82[i] <= num_s81[i][MV-1] ? MV'(-num_s81[i]) : MV'(num_s81[i]);
				nneg_s82[i] <= num_s81[i][MV-1];
			end
			br_s82 <= br_s81;
		end
	end

	// square root of the branch radicand in Q2.30
	logic [S_W-1:0] s_root;

	latq_isqrt #(.NB(SQ2_NB)) u_sqrt_q (
		.clk(clk), .en(en), .rad({rad_s81, 30'd0}), .root(s_root)
	);

	logic [3*MV+5-1:0] mid_flat;

	latq_delay #(.WD(3*MV+5), .DEPTH(SQ2_NB/2 - 1)) u_dl_mid (
		.clk(clk), .en(en),
		.din({nmag_s82[0], nmag_s82[1], nmag_s82[2], nneg_s82, br_s82}),
		.dout(mid_flat)
	);

	// zero root counts as one LSB; halving rounds up
	logic [S_W-1:0] s_den;
	logic [S_W:0]   s_inc;
	logic [Q_W-1:0] half_d;

	assign s_den  = (s_root == '0) ? S_W'(1) : s_root;
	assign s_inc  = (S_W+1)'(s_den) + (S_W+1)'(1);
	assign half_d = Q_W'(s_inc >> 1);

	logic [Q_W-1:0] q2  [3];
	logic           ov2 [3];

	for (genvar i = 0; i < 3; i++) begin : g_quat
		latq_div #(.NW(D2_NW), .DW(S_W), .QW(Q_W)) u_div (
			.clk(clk), .en(en),
			.mag({mid_flat[(3-i)*MV+5-1 -: MV], SCALE_MSB'(0)}),
			.den(s_den),
			.quo(q2[i]), .ovf(ov2[i])
		);
	end

	logic [Q_W+5-1:0] tail_flat;
	logic             deg_dl;

	latq_delay #(.WD(Q_W+5), .DEPTH(DV_LAT)) u_dl_tail (
		.clk(clk), .en(en), .din({mid_flat[4:0], half_d}), .dout(tail_flat)
	);
	latq_delay #(.WD(1), .DEPTH(LAT - 1 - (2 + BS_LAT + 3 + BS_LAT))) u_dl_deg (
		.clk(clk), .en(en), .din(deg_s9), .dout(deg_dl)
	);

	// saturate a magnitude to one and apply its sign
	function automatic logic [Q_W-1:0] sat_q(input logic [Q_W-1:0] q, input logic ovf,
	                                         input logic neg);
		logic [Q_W-1:0] m;
		m = (ovf || (q > Q_W'(ONE_Q30))) ? Q_W'(ONE_Q30) : q;
		return neg ? -m : m;
	endfunction

	// final stage: place components by branch; degenerate gives identity
	// numerator signs sit at Q_W+2 (first) up to Q_W+4 (third)
	logic [Q_W-1:0] v0, v1, v2, hv;
	branch_t        br_f;
	out_t           out_d;

	always_comb begin
		br_f = branch_t'(tail_flat[Q_W+1:Q_W]);
		v0   = sat_q(q2[0], ov2[0], tail_flat[Q_W+2]);
		v1   = sat_q(q2[1], ov2[1], tail_flat[Q_W+3]);
		v2   = sat_q(q2[2], ov2[2], tail_flat[Q_W+4]);
		hv   = sat_q(tail_flat[Q_W-1:0], 1'b0, 1'b0);
		out_d.degenerate = 1'b0;
		case (br_f)
			BR_TRACE: begin
				out_d.quat_x = v0; out_d.quat_y = v1; out_d.quat_z = v2; out_d.quat_w = hv;
			end
			BR_X: begin
				out_d.quat_x = hv; out_d.quat_y = v0; out_d.quat_z = v1; out_d.quat_w = v2;
			end
			BR_Y: begin
				out_d.quat_x = v0; out_d.quat_y = hv; out_d.quat_z = v1; out_d.quat_w = v2;
			end
			default: begin
				out_d.quat_x = v0; out_d.quat_y = v1; out_d.quat_z = hv; out_d.quat_w = v2;
			end
		endcase
		if (deg_dl) begin
			out_d.quat_x     = '0;
			out_d.quat_y     = '0;
			out_d.quat_z     = '0;
			out_d.quat_w     = Q_W'(ONE_Q30);
			out_d.degenerate = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= out_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/latq_delay.sv */
// Enabled shift line that carries side data alongside a pipelined unit.
`default_nettype none

module latq_delay #(
	parameter int WD    = 8,
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [WD-1:0] din,
	output logic [WD-1:0] dout
);
	logic [WD-1:0] sh_q [DEPTH];

	// shift on every advance
	always_ff @(posedge clk) begin
		if (en) begin
			sh_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				sh_q[i] <= sh_q[i-1];
			end
		end
	end

	assign dout = sh_q[DEPTH-1];

endmodule

`default_nettype wire

/* rtl/latq_bscale.sv */
// Two-stage block scaler: common shift of three magnitudes to put the top at SCALE_MSB.
`default_nettype none

module latq_bscale #(
	parameter int MW = 33
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [MW-1:0]                       mag [3],
	input  logic [2:0]                          neg,
	output logic signed [latq_pkg::SCALE_W-1:0] sv [3],
	output logic                                zero
);
	import latq_pkg::*;

	localparam int PW = (MW > 1) ? $clog2(MW) : 1;
	localparam int AW = (PW > 5) ? PW : 5;
	localparam int LW = MW + SCALE_MSB + 1;

	logic [MW-1:0] orv;
	logic [PW-1:0] pos;
	logic          right_d;
	logic [AW-1:0] amt_d;

	logic [MW-1:0] mag_a [3];
	logic [2:0]    neg_a;
	logic          right_a;
	logic [AW-1:0] amt_a;
	logic          zero_a;

	logic [LW-1:0] wide [3];

	// leading one of the OR equals leading one of the largest magnitude
	always_comb begin
		orv = mag[0] | mag[1] | mag[2];
		pos = '0;
		for (int b = 0; b < MW; b++) begin
			if (orv[b]) begin
				pos = PW'(b);
			end
		end
		right_d = (int'(pos) >= SCALE_MSB);
		amt_d   = right_d ? AW'(int'(pos) - SCALE_MSB) : AW'(SCALE_MSB - int'(pos));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_a   <= mag;
			neg_a   <= neg;
			right_a <= right_d;
			amt_a   <= amt_d;
			zero_a  <= (orv == '0);
		end
	end

	// apply the shift, right shift truncates the magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide[i] = right_a ? (LW'(mag_a[i]) >> amt_a) : (LW'(mag_a[i]) << amt_a);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sv[i] <= neg_a[i] ? -SCALE_W'(wide[i][SCALE_MSB:0])
				                  : SCALE_W'(wide[i][SCALE_MSB:0]);
			end
			zero <= zero_a;
		end
	end

endmodule

`default_nettype wire

/* rtl/latq_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module latq_isqrt #(
	parameter int NB = 64
) (
	input  logic            clk,
	input  logic            en,
	input  logic [NB-1:0]   rad,
	output logic [NB/2-1:0] root
);
	localparam int ST = NB / 2;

	logic [NB-1:0] n_q [ST];
	logic [NB-1:0] r_q [ST];
	logic [NB-1:0] n_d [ST];
	logic [NB-1:0] r_d [ST];

	// one digit step per stage, bit walks down by powers of four
	always_comb begin
		logic [NB-1:0] n_p;
		logic [NB-1:0] r_p;
		logic [NB-1:0] bitv;
		logic [NB:0]   trial;
		for (int i = 0; i < ST; i++) begin
			if (i == 0) begin
				n_p = rad;
				r_p = '0;
			end else begin
				n_p = n_q[i-1];
				r_p = r_q[i-1];
			end
			bitv  = NB'(1) << (NB - 2 - 2 * i);
			trial = {1'b0, r_p} + {1'b0, bitv};
			if ({1'b0, n_p} >= trial) begin
				n_d[i] = n_p - trial[NB-1:0];
				r_d[i] = (r_p >> 1) + bitv;
			end else begin
				n_d[i] = n_p;
				r_d[i] = r_p >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_q <= n_d;
			r_q <= r_d;
		end
	end

	assign root = r_q[ST-1][ST-1:0];

endmodule

`default_nettype wire

/* rtl/latq_div.sv */
// Pipelined restoring divider with round half up and quotient overflow flag.
`default_nettype none

module latq_div #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] mag,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);
	localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [RW-1:0] rem_q [QW+1];
	logic [DW-1:0] den_q [QW+1];
	logic [QW-1:0] quo_q [QW+1];
	logic          ovf_q [QW+1];

	logic [RW-1:0] rem_d [QW+1];
	logic [QW-1:0] quo_d [QW+1];

	// input stage adds half the divisor; later stages each settle one quotient bit
	always_comb begin
		logic [RW-1:0] trial;
		rem_d[0] = RW'(mag) + RW'(den >> 1);
		quo_d[0] = '0;
		for (int i = 1; i <= QW; i++) begin
			trial    = RW'(den_q[i-1]) << (QW - i);
			rem_d[i] = rem_q[i-1];
			quo_d[i] = quo_q[i-1];
			if (rem_q[i-1] >= trial) begin
				rem_d[i]        = rem_q[i-1] - trial;
				quo_d[i][QW-i]  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= rem_d[0];
			den_q[0] <= den;
			quo_q[0] <= quo_d[0];
			ovf_q[0] <= (rem_d[0] >= (RW'(den) << QW));
			for (int i = 1; i <= QW; i++) begin
				rem_q[i] <= rem_d[i];
				den_q[i] <= den_q[i-1];
				quo_q[i] <= quo_d[i];
				ovf_q[i] <= ovf_q[i-1];
			end
		end
	end

	assign quo = quo_q[QW];
	assign ovf = ovf_q[QW];

endmodule

`default_nettype wire
